@@ rtl/core/dehd_pkg.sv @@
`default_nettype none

package dehd_pkg;

    // Fixed widths of the item and register fields
    localparam int PIN_SLOTS   = 8;
    localparam int TIMER_W     = 32;
    localparam int HOLD_W      = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    // Defaults for the top level parameters
    localparam int NODES_DEF     = 8;
    localparam int TIME_BITS_DEF = 32;

    // Register map
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEBOUNCE_PERIOD     = 3'd0,
        CFG_PRESS_HOLD_TICKS    = 3'd1,
        CFG_RELEASE_HOLD_TICKS  = 3'd2,
        CFG_PRESS_ENABLE_MASK   = 3'd3,
        CFG_RELEASE_ENABLE_MASK = 3'd4
    } t_cfg_index;

endpackage

`default_nettype wire

@@ rtl/core/debounced_edge_hold_detector.sv @@
// Debounced edge and hold detector for up to eight input pins.
// Input channel: one beat per tick of a slow timebase, carrying the pin levels
// (i_in_valid / o_in_ready / i_pin_levels). Output channel: exactly one result
// beat per input beat (o_out_valid / i_out_ready) with the sample flag and the
// rising, falling, pressed and released pin masks of that tick.
// A free-running sample timer picks every debounce_period-th tick as a sample;
// only sample ticks compare pins, report events and change pin state.
// The result of a beat is registered and presented in the cycle after it is accepted.
// Throughput: one beat per cycle unless stalled; all per-pin logic sits between
// the accepted input and the result register, and the state updates in the same cycle.
// Stall: a held result keeps its register; a new beat is still taken in the
// cycle the receiver takes the held one, otherwise o_in_ready drops.
// Configuration: plain write port (i_cfg_we, i_cfg_index, i_cfg_data); write
// only while the block is idle. Unknown indexes are ignored.
// Reset (synchronous, active low): configuration registers, sample timer, last sampled
// levels, arm bits and elapsed counters return to zero; the output goes empty.
`default_nettype none

module debounced_edge_hold_detector #(
    parameter int NODES     = dehd_pkg::NODES_DEF,
    parameter int TIME_BITS = dehd_pkg::TIME_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic [dehd_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [dehd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [dehd_pkg::PIN_SLOTS-1:0]     i_pin_levels,
    // output channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic                                    o_sampled,
    output logic [dehd_pkg::PIN_SLOTS-1:0]          o_rising_mask,
    output logic [dehd_pkg::PIN_SLOTS-1:0]          o_falling_mask,
    output logic [dehd_pkg::PIN_SLOTS-1:0]          o_pressed_mask,
    output logic [dehd_pkg::PIN_SLOTS-1:0]          o_released_mask
);

    localparam int PINS  = (NODES < dehd_pkg::PIN_SLOTS) ? NODES : dehd_pkg::PIN_SLOTS;
    localparam int CMP_W = (TIME_BITS > dehd_pkg::HOLD_W) ? TIME_BITS : dehd_pkg::HOLD_W;

    // configuration registers
    logic [dehd_pkg::TIMER_W-1:0]   r_debounce_period;
    logic [dehd_pkg::HOLD_W-1:0]    r_press_hold;
    logic [dehd_pkg::HOLD_W-1:0]    r_release_hold;
    logic [PINS-1:0]                r_press_en;
    logic [PINS-1:0]                r_release_en;

    // pin state
    logic [dehd_pkg::TIMER_W-1:0]   r_timer,        n_timer;
    logic [PINS-1:0]                r_prev,         n_prev;
    logic [PINS-1:0]                r_press_armed,  n_press_armed;
    logic [PINS-1:0]                r_release_armed, n_release_armed;
    logic [TIME_BITS-1:0]           r_elapsed [PINS];
    logic [TIME_BITS-1:0]           n_elapsed [PINS];

    // result register
    logic                           r_out_valid;
    logic                           r_sampled,      n_sampled;
    logic [dehd_pkg::PIN_SLOTS-1:0] r_rise,         n_rise;
    logic [dehd_pkg::PIN_SLOTS-1:0] r_fall,         n_fall;
    logic [dehd_pkg::PIN_SLOTS-1:0] r_press,        n_press;
    logic [dehd_pkg::PIN_SLOTS-1:0] r_release,      n_release;

    logic                           in_fire;
    logic                           out_fire;
    logic [dehd_pkg::TIMER_W-1:0]   timer_inc;
    logic [TIME_BITS-1:0]           el_inc [PINS];
    logic [CMP_W-1:0]               el_ext [PINS];

    // take a beat whenever the result register is empty or being emptied
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_fire   = r_out_valid && i_out_ready;

    // advance timer and counters, then compare pins on a sample tick
    always_comb begin
        timer_inc = (r_timer == '1) ? r_timer : r_timer + 1'b1;
        n_sampled = (timer_inc >= r_debounce_period);
        n_timer   = n_sampled ? '0 : timer_inc;

        n_prev          = r_prev;
        n_press_armed   = r_press_armed;
        n_release_armed = r_release_armed;
        n_rise          = '0;
        n_fall          = '0;
        n_press         = '0;
        n_release       = '0;

        for (int i = 0; i < PINS; i++) begin
            el_inc[i]    = (r_elapsed[i] == '1) ? r_elapsed[i] : r_elapsed[i] + 1'b1;
            el_ext[i]    = CMP_W'(el_inc[i]);
            n_elapsed[i] = el_inc[i];
            if (n_sampled) begin
                if (i_pin_levels[i] != r_prev[i]) begin
                    n_elapsed[i] = '0;
                    if (i_pin_levels[i]) begin
                        n_rise[i]        = 1'b1;
                        n_press_armed[i] = 1'b1;
                    end else begin
                        n_fall[i]          = 1'b1;
                        n_release_armed[i] = 1'b1;
                    end
                end else begin
                    if (r_press_armed[i] && r_press_en[i] && i_pin_levels[i] &&
                        el_ext[i] >= CMP_W'(r_press_hold)) begin
                        n_press[i]       = 1'b1;
                        n_press_armed[i] = 1'b0;
                    end
                    if (r_release_armed[i] && r_release_en[i] && !i_pin_levels[i] &&
                        el_ext[i] >= CMP_W'(r_release_hold)) begin
                        n_release[i]       = 1'b1;
                        n_release_armed[i] = 1'b0;
                    end
                end
                n_prev[i] = i_pin_levels[i];
            end
        end
    end

    // hold configuration, pin state and the result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_period <= '0;
            r_press_hold      <= '0;
            r_release_hold    <= '0;
            r_press_en        <= '0;
            r_release_en      <= '0;
            r_timer           <= '0;
            r_prev            <= '0;
            r_press_armed     <= '0;
            r_release_armed   <= '0;
            for (int i = 0; i < PINS; i++) begin
                r_elapsed[i] <= '0;
            end
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    dehd_pkg::CFG_DEBOUNCE_PERIOD:     r_debounce_period <= i_cfg_data;
                    dehd_pkg::CFG_PRESS_HOLD_TICKS:    r_press_hold      <= i_cfg_data;
                    dehd_pkg::CFG_RELEASE_HOLD_TICKS:  r_release_hold    <= i_cfg_data;
                    dehd_pkg::CFG_PRESS_ENABLE_MASK:   r_press_en   <= i_cfg_data[PINS-1:0];
                    dehd_pkg::CFG_RELEASE_ENABLE_MASK: r_release_en <= i_cfg_data[PINS-1:0];
                    default: begin
                    end
                endcase
            end
            if (in_fire) begin
                r_timer         <= n_timer;
                r_prev          <= n_prev;
                r_press_armed   <= n_press_armed;
                r_release_armed <= n_release_armed;
                for (int i = 0; i < PINS; i++) begin
                    r_elapsed[i] <= n_elapsed[i];
                end
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // load the result payload with each accepted beat
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_sampled <= n_sampled;
            r_rise    <= n_rise;
            r_fall    <= n_fall;
            r_press   <= n_press;
            r_release <= n_release;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sampled       = r_sampled;
    assign o_rising_mask   = r_rise;
    assign o_falling_mask  = r_fall;
    assign o_pressed_mask  = r_press;
    assign o_released_mask = r_release;

    // events appear only on sample ticks
    a_events_on_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_sampled) |->
            (r_rise == '0 && r_fall == '0 && r_press == '0 && r_release == '0))
        else $error("event reported on a non-sample tick");

    // a pin has at most one edge and no hold event in the tick of its edge
    a_edge_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |->
            ((r_rise & r_fall) == '0 && ((r_press | r_release) & (r_rise | r_fall)) == '0))
        else $error("conflicting events on one pin");

    // a pin cannot complete press and release in the same tick
    a_hold_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_press & r_release) == '0)
        else $error("pressed and released on one pin");

    // an accepted beat always leaves a result behind
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_out_valid)
        else $error("accepted beat produced no result");

endmodule

`default_nettype wire

@@ bench/debounced_edge_hold_detector_tb.sv @@
`timescale 1ns / 100ps

module debounced_edge_hold_detector_tb;

    localparam int PINS        = dehd_pkg::PIN_SLOTS;
    localparam int ELAPSED_W   = dehd_pkg::TIME_BITS_DEF;
    localparam int CFG_INDEX_W = dehd_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = dehd_pkg::CFG_DATA_W;
    localparam int TIMER_W     = dehd_pkg::TIMER_W;
    localparam int HOLD_W      = dehd_pkg::HOLD_W;
    localparam int CYCLE_LIMIT = 500_000;
    localparam int PRINT_LIMIT = 60;
    localparam int MAX_GAP     = 16;
    localparam int CHUNK_BEATS = 51;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAST_INDEX = '1;

    // Events of one tick as the block reports them
    typedef struct packed {
        logic             sampled;
        logic [PINS-1:0]  rising;
        logic [PINS-1:0]  falling;
        logic [PINS-1:0]  pressed;
        logic [PINS-1:0]  released;
    } t_tick_events;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [PINS-1:0]        i_pin_levels = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic                   o_sampled;
    logic [PINS-1:0]        o_rising_mask;
    logic [PINS-1:0]        o_falling_mask;
    logic [PINS-1:0]        o_pressed_mask;
    logic [PINS-1:0]        o_released_mask;

    debounced_edge_hold_detector i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_pin_levels    (i_pin_levels),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_sampled       (o_sampled),
        .o_rising_mask   (o_rising_mask),
        .o_falling_mask  (o_falling_mask),
        .o_pressed_mask  (o_pressed_mask),
        .o_released_mask (o_released_mask)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Detector state and registers as the block should hold them
    logic [TIMER_W-1:0]   cfg_period = '0;
    logic [HOLD_W-1:0]    cfg_press_hold = '0;
    logic [HOLD_W-1:0]    cfg_release_hold = '0;
    logic [PINS-1:0]      cfg_press_en = '0;
    logic [PINS-1:0]      cfg_release_en = '0;
    logic [TIMER_W-1:0]   sample_count = '0;
    logic [PINS-1:0]      last_levels = '0;
    logic [PINS-1:0]      press_armed_bits = '0;
    logic [PINS-1:0]      release_armed_bits = '0;
    logic [ELAPSED_W-1:0] pin_elapsed [PINS] = '{default: '0};

    t_tick_events pending_events[$];
    t_tick_events next_want;
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           in_idle_pct = 0;
    int           out_idle_pct = 0;

    // Advance the detector state by one tick and return its events
    function automatic t_tick_events predict_tick(logic [PINS-1:0] levels);
        t_tick_events ev;
        ev = '0;
        for (int p = 0; p < PINS; p++) begin
            if (pin_elapsed[p] != '1)
                pin_elapsed[p] = pin_elapsed[p] + 1'b1;
        end
        if (sample_count != '1)
            sample_count = sample_count + 1'b1;
        if (sample_count >= cfg_period) begin
            sample_count = '0;
            ev.sampled = 1'b1;
            for (int p = 0; p < PINS; p++) begin
                if (levels[p] != last_levels[p]) begin
                    // edge: restart the hold count and arm the matching hold event
                    pin_elapsed[p] = '0;
                    if (levels[p]) begin
                        ev.rising[p] = 1'b1;
                        press_armed_bits[p] = 1'b1;
                    end else begin
                        ev.falling[p] = 1'b1;
                        release_armed_bits[p] = 1'b1;
                    end
                end else begin
                    if (press_armed_bits[p] && cfg_press_en[p] && levels[p] &&
                        pin_elapsed[p] >= cfg_press_hold) begin
                        ev.pressed[p] = 1'b1;
                        press_armed_bits[p] = 1'b0;
                    end
                    if (release_armed_bits[p] && cfg_release_en[p] && !levels[p] &&
                        pin_elapsed[p] >= cfg_release_hold) begin
                        ev.released[p] = 1'b1;
                        release_armed_bits[p] = 1'b0;
                    end
                end
            end
            last_levels = levels;
        end
        return ev;
    endfunction

    task automatic report_mismatch(input string what, input logic [PINS-1:0] got,
                                   input logic [PINS-1:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0d] mismatch on %s: got %h, expected %h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Drive one tick beat after a random gap and record its expected events
    task automatic send_levels(input logic [PINS-1:0] levels);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < in_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_pin_levels <= levels;
        do @(posedge i_clk); while (!o_in_ready);
        pending_events.push_back(predict_tick(levels));
    endtask

    // Hold the sender until every expected beat has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller drops it
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (index)
            dehd_pkg::CFG_DEBOUNCE_PERIOD:     cfg_period = data;
            dehd_pkg::CFG_PRESS_HOLD_TICKS:    cfg_press_hold = data;
            dehd_pkg::CFG_RELEASE_HOLD_TICKS:  cfg_release_hold = data;
            dehd_pkg::CFG_PRESS_ENABLE_MASK:   cfg_press_en = data[PINS-1:0];
            dehd_pkg::CFG_RELEASE_ENABLE_MASK: cfg_release_en = data[PINS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [TIMER_W-1:0] period,
                              input logic [HOLD_W-1:0] press_hold,
                              input logic [HOLD_W-1:0] release_hold,
                              input logic [PINS-1:0] press_en,
                              input logic [PINS-1:0] release_en);
        drain_results();
        write_reg(dehd_pkg::CFG_DEBOUNCE_PERIOD, period);
        write_reg(dehd_pkg::CFG_PRESS_HOLD_TICKS, press_hold);
        write_reg(dehd_pkg::CFG_RELEASE_HOLD_TICKS, release_hold);
        write_reg(dehd_pkg::CFG_PRESS_ENABLE_MASK, CFG_DATA_W'(press_en));
        write_reg(dehd_pkg::CFG_RELEASE_ENABLE_MASK, CFG_DATA_W'(release_en));
        i_cfg_we <= 1'b0;
    endtask

    // Reset registers: every tick samples, all pins rise and then fall, no hold events
    task automatic test_reset_defaults();
        send_levels(8'hFF);
        send_levels(8'hFF);
        send_levels(8'h00);
    endtask

    // Armed pins wait out a disabled event and fire once it is enabled
    task automatic test_disabled_hold();
        set_config(0, 0, 0, 8'h00, 8'h0F);
        send_levels(8'h00);
        set_config(0, 0, 0, 8'hFF, 8'hFF);
        send_levels(8'h00);
        send_levels(8'h5A);
        send_levels(8'h5A);
    endtask

    task automatic test_hold_times();
        set_config(0, 3, 2, 8'hFF, 8'hFF);
        send_levels(8'hFF);
        repeat (3) send_levels(8'hFF);
        send_levels(8'h00);
        repeat (2) send_levels(8'h00);
    endtask

    // Changes between sample ticks are never seen
    task automatic test_debounce_period();
        set_config(2, 1, 1, 8'hFF, 8'hFF);
        send_levels(8'h00);
        send_levels(8'hFF);
        send_levels(8'h0F);
        send_levels(8'h0F);
        send_levels(8'hF0);
    endtask

    // Largest period gives no sample and largest hold no hold event within this test
    task automatic test_extremes();
        set_config('1, '1, '1, 8'hFF, 8'hFF);
        send_levels(8'hAA);
        send_levels(8'h55);
        set_config(1, '1, '1, 8'hFF, 8'hFF);
        send_levels(8'hAA);
        send_levels(8'hAA);
        send_levels(8'h55);
    endtask

    // Writes past the register map must not disturb anything
    task automatic test_unknown_index();
        drain_results();
        for (int idx = dehd_pkg::CFG_RELEASE_ENABLE_MASK + 1; idx <= CFG_LAST_INDEX; idx++)
            write_reg(CFG_INDEX_W'(idx), '1);
        i_cfg_we <= 1'b0;
        send_levels(8'h55);
        send_levels(8'h55);
    endtask

    // Stable pin patterns with random holds, sprinkled with single-tick glitches
    task automatic test_random_traffic(input int chunks, input int in_pct, input int out_pct);
        logic [TIMER_W-1:0] period;
        logic [HOLD_W-1:0]  press_hold;
        logic [HOLD_W-1:0]  release_hold;
        logic [PINS-1:0]    steady;
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        for (int c = 0; c < chunks; c++) begin
            case ($urandom_range(9))
                0: period = 0;
                1: period = 1;
                9: period = $urandom_range(6, 12);
                default: period = $urandom_range(2, 4);
            endcase
            press_hold   = ($urandom_range(15) == 0) ? $urandom : $urandom_range(0, 12);
            release_hold = ($urandom_range(15) == 0) ? $urandom : $urandom_range(0, 12);
            set_config(period, press_hold, release_hold,
                       ($urandom_range(2) == 0) ? 8'hFF : PINS'($urandom_range(255)),
                       ($urandom_range(2) == 0) ? 8'hFF : PINS'($urandom_range(255)));
            steady = PINS'($urandom_range(255));
            for (int k = 0; k < CHUNK_BEATS; k++) begin
                if ($urandom_range(15) == 0)
                    steady = steady ^ PINS'($urandom_range(1, 255));
                if ($urandom_range(19) == 0)
                    send_levels(PINS'($urandom_range(255)));
                else
                    send_levels(steady);
                if ($urandom_range(199) == 0)
                    drain_results();
            end
        end
    endtask

    // Check each result beat against the oldest expectation; stall the receiver
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_events.size() == 0) begin
                report_mismatch("unexpected beat", '0, '0);
            end else begin
                next_want = pending_events.pop_front();
                if (o_sampled !== next_want.sampled)
                    report_mismatch("sampled", PINS'(o_sampled), PINS'(next_want.sampled));
                if (o_rising_mask !== next_want.rising)
                    report_mismatch("rising_mask", o_rising_mask, next_want.rising);
                if (o_falling_mask !== next_want.falling)
                    report_mismatch("falling_mask", o_falling_mask, next_want.falling);
                if (o_pressed_mask !== next_want.pressed)
                    report_mismatch("pressed_mask", o_pressed_mask, next_want.pressed);
                if (o_released_mask !== next_want.released)
                    report_mismatch("released_mask", o_released_mask, next_want.released);
            end
        end
        i_out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        in_idle_pct  = 24;
        out_idle_pct = 86;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_disabled_hold();
        test_hold_times();
        test_debounce_period();
        test_extremes();
        test_unknown_index();
        test_random_traffic(10, 24, 86);
        test_random_traffic(10, 86, 24);
        test_random_traffic(10, 0, 0);

        drain_results();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ debounced_edge_hold_detector.f @@
rtl/core/dehd_pkg.sv
rtl/core/debounced_edge_hold_detector.sv
bench/debounced_edge_hold_detector_tb.sv
